>>> design/pse_pkg.sv
`default_nettype none

package pse_pkg;

	// Field widths of the point and result items
	localparam int POS_W    = 24;
	localparam int TIME_W   = 32;
	localparam int SPEED_W  = 40;
	localparam int STATUS_W = 2;

	// Internal widths: position difference, its square sum, root and root remainder
	localparam int DIFF_W   = POS_W + 1;
	localparam int RAD_W    = 2 * DIFF_W;
	localparam int DIST_W   = RAD_W / 2;
	localparam int SQ_REM_W = DIST_W + 4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_PRED  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO_INT = 2'd2;

	// Saturation limits, compared against a zero-extended 64-bit quotient
	localparam logic [63:0] SAT_POS_LIM = 64'h0000_007F_FFFF_FFFF;
	localparam logic [63:0] SAT_NEG_LIM = 64'h0000_0080_0000_0000;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [SPEED_W-1:0] SPEED_MIN = 40'h80_0000_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_X,
		S_MUL_Y,
		S_SQRT,
		S_DIV_INIT,
		S_DIV,
		S_SAT,
		S_DONE
	} pse_state_t;

	// Step strobes from the sequencer to the datapath
	typedef struct packed {
		logic in_ready;
		logic mul_x;
		logic mul_y;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic sat;
		logic out_load;
	} pse_ctrl_t;

endpackage

`default_nettype wire

>>> design/pse_in_if.sv
`default_nettype none

interface pse_in_if;
	import pse_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic        [TIME_W-1:0] time_stamp;
	logic                     path_start;

	modport source (output valid, output pos_x, output pos_y, output time_stamp,
		output path_start, input ready);
	modport sink (input valid, input pos_x, input pos_y, input time_stamp,
		input path_start, output ready);
endinterface

`default_nettype wire

>>> design/pse_out_if.sv
`default_nettype none

interface pse_out_if;
	import pse_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SPEED_W-1:0]  speed;
	logic        [STATUS_W-1:0] status;

	modport source (output valid, output speed, output status, input ready);
	modport sink (input valid, input speed, input status, output ready);
endinterface

`default_nettype wire

>>> design/path_speed_estimator_core.sv
`default_nettype none

// Channel  Dir  Payload                               Transfer
// point    in   pos_x, pos_y, time_stamp, path_start  valid & ready
// result   out  speed, status                         valid & ready
//
// A point that starts a path, does not move, or moves in a zero interval
// goes straight to the done state and loads its result once the result
// register is free. Any other point runs two multiply steps, then 25 square-root
// steps and 25 + SPEED_FRAC_BITS division steps on one compare-subtract unit.
// point.ready is high only while the sequencer is idle; the result register
// lets the next point in while a finished result waits.
// arst_n clears the sequencer, the stored point flag and the result valid.

module path_speed_estimator_core #(
	parameter int POS_FRAC_BITS   = 8,
	parameter int SPEED_FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pse_in_if.sink     point,
	pse_out_if.source  result
);
	import pse_pkg::*;

	localparam int DEN_W  = TIME_W + POS_FRAC_BITS;
	localparam int NUM_W  = DIST_W + SPEED_FRAC_BITS;
	localparam int UNIT_W = (DEN_W + 1 > SQ_REM_W) ? DEN_W + 1 : SQ_REM_W;

	pse_ctrl_t ctrl;

	// Stored point
	logic signed [POS_W-1:0]  prev_x_q;
	logic signed [POS_W-1:0]  prev_y_q;
	logic        [TIME_W-1:0] prev_time_q;
	logic                     have_prev_q;

	// Work registers
	logic [DIFF_W-1:0]   adx_q;
	logic [DIFF_W-1:0]   ady_q;
	logic [TIME_W-1:0]   mag_q;
	logic                neg_q;
	logic [RAD_W-1:0]    acc_q;
	logic [DIST_W-1:0]   root_q;
	logic [UNIT_W-1:0]   rem_q;
	logic [NUM_W-1:0]    num_q;
	logic [SPEED_W-1:0]  res_speed_q;
	logic [STATUS_W-1:0] res_status_q;

	// Result register
	logic                out_valid_q;
	logic [SPEED_W-1:0]  out_speed_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                     accept;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]        adx;
	logic [DIFF_W-1:0]        ady;
	logic [TIME_W:0]          delta;
	logic [TIME_W-1:0]        mag;
	logic                     no_pred;
	logic                     no_move;
	logic                     zero_int;
	logic                     quick;
	logic                     out_free;

	logic [DIFF_W-1:0]   mul_a;
	logic [RAD_W-1:0]    prod;
	logic [SQ_REM_W-1:0] sq_shift;
	logic [DEN_W:0]      dv_shift;
	logic [DEN_W-1:0]    den;
	logic [UNIT_W-1:0]   unit_a;
	logic [UNIT_W-1:0]   unit_b;
	logic [UNIT_W-1:0]   unit_diff;
	logic                unit_ge;
	logic [63:0]         q64;
	logic [63:0]         q64_neg;

	assign accept   = point.valid && ctrl.in_ready;
	assign out_free = !out_valid_q || result.ready;

	// Classify the point against the stored one
	assign dx       = DIFF_W'(point.pos_x) - DIFF_W'(prev_x_q);
	assign dy       = DIFF_W'(point.pos_y) - DIFF_W'(prev_y_q);
	assign adx      = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ady      = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	assign delta    = {1'b0, point.time_stamp} - {1'b0, prev_time_q};
	assign mag      = delta[TIME_W] ? TIME_W'(-delta) : delta[TIME_W-1:0];
	assign no_pred  = point.path_start || !have_prev_q;
	assign no_move  = (dx == '0) && (dy == '0);
	assign zero_int = (point.time_stamp == prev_time_q);
	assign quick    = no_pred || no_move || zero_int;

	pse_ctrl #(
		.NUM_W (NUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.quick    (quick),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Squares of the differences share one multiplier
	assign mul_a = ctrl.mul_y ? ady_q : adx_q;
	assign prod  = mul_a * mul_a;

	// Operands of the shared compare-subtract unit
	assign sq_shift = {rem_q[SQ_REM_W-3:0], acc_q[RAD_W-1 -: 2]};
	assign den      = DEN_W'(mag_q) << POS_FRAC_BITS;
	assign dv_shift = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};

	always_comb begin
		if (ctrl.div_step) begin
			unit_a = UNIT_W'(dv_shift);
			unit_b = UNIT_W'(den);
		end else begin
			unit_a = UNIT_W'(sq_shift);
			unit_b = UNIT_W'({root_q, 2'b01});
		end
	end

	pse_cmpsub #(
		.W (UNIT_W)
	) u_unit (
		.a    (unit_a),
		.b    (unit_b),
		.diff (unit_diff),
		.ge   (unit_ge)
	);

	assign q64     = 64'(num_q);
	assign q64_neg = 64'd0 - q64;

	// Stored point: update unless a moving point with a predecessor has a zero interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_time_q <= '0;
			have_prev_q <= 1'b0;
		end else if (accept && (no_pred || no_move || !zero_int)) begin
			prev_x_q    <= point.pos_x;
			prev_y_q    <= point.pos_y;
			prev_time_q <= point.time_stamp;
			have_prev_q <= 1'b1;
		end
	end

	// Datapath: latch, square, root, divide, saturate
	always_ff @(posedge clk) begin
		if (accept) begin
			adx_q        <= adx;
			ady_q        <= ady;
			mag_q        <= mag;
			neg_q        <= delta[TIME_W];
			res_speed_q  <= '0;
			if (no_pred) begin
				res_status_q <= STAT_NO_PRED;
			end else if (!no_move && zero_int) begin
				res_status_q <= STAT_ZERO_INT;
			end else begin
				res_status_q <= STAT_OK;
			end
		end
		if (ctrl.mul_x) begin
			acc_q <= prod;
		end
		if (ctrl.mul_y) begin
			acc_q  <= acc_q + prod;
			root_q <= '0;
			rem_q  <= '0;
		end
		if (ctrl.sqrt_step) begin
			acc_q  <= {acc_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[DIST_W-2:0], unit_ge};
			rem_q  <= unit_ge ? unit_diff : UNIT_W'(sq_shift);
		end
		if (ctrl.div_init) begin
			num_q <= NUM_W'(root_q) << SPEED_FRAC_BITS;
			rem_q <= '0;
		end
		if (ctrl.div_step) begin
			num_q <= {num_q[NUM_W-2:0], unit_ge};
			rem_q <= unit_ge ? unit_diff : UNIT_W'(dv_shift);
		end
		if (ctrl.sat) begin
			if (!neg_q) begin
				res_speed_q <= (q64 > SAT_POS_LIM) ? SPEED_MAX : q64[SPEED_W-1:0];
			end else begin
				res_speed_q <= (q64 > SAT_NEG_LIM) ? SPEED_MIN : q64_neg[SPEED_W-1:0];
			end
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_speed_q  <= res_speed_q;
			out_status_q <= res_status_q;
		end
	end

	assign point.ready   = ctrl.in_ready;
	assign result.valid  = out_valid_q;
	assign result.speed  = out_speed_q;
	assign result.status = out_status_q;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !point.ready)
		else $error("point taken while previous point still in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status == STAT_OK || result.status == STAT_NO_PRED ||
			result.status == STAT_ZERO_INT))
		else $error("result status outside defined codes");

	a_speed_zero_on_special: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != STAT_OK |-> result.speed == '0)
		else $error("nonzero speed with special status");

	a_start_stores: assert property (@(posedge clk) disable iff (!arst_n)
		accept && point.path_start |=> have_prev_q)
		else $error("path start point not stored");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> out_free)
		else $error("result register overwritten before taken");

endmodule

`default_nettype wire

>>> design/pse_cmpsub.sv
`default_nettype none

module pse_cmpsub #(
	parameter int W = 33
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);
	logic [W:0] wide;

	// Subtract with borrow out; no borrow means a >= b
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[W-1:0];
	assign ge   = ~wide[W];
endmodule

`default_nettype wire

>>> design/pse_ctrl.sv
`default_nettype none

module pse_ctrl #(
	parameter int NUM_W = 41
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            quick,
	input  wire logic            out_free,
	output pse_pkg::pse_ctrl_t   ctrl
);
	import pse_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	pse_state_t       state_q;
	pse_state_t       state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             last;

	assign last = (cnt_q == '0);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = quick ? S_DONE : S_MUL_X;
				end
			end
			S_MUL_X:    state_nxt = S_MUL_Y;
			S_MUL_Y:    state_nxt = S_SQRT;
			S_SQRT: begin
				if (last) begin
					state_nxt = S_DIV_INIT;
				end
			end
			S_DIV_INIT: state_nxt = S_DIV;
			S_DIV: begin
				if (last) begin
					state_nxt = S_SAT;
				end
			end
			S_SAT:      state_nxt = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:    state_nxt = S_IDLE;
		endcase
	end

	// Step strobes
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE:     ctrl.in_ready  = 1'b1;
			S_MUL_X:    ctrl.mul_x     = 1'b1;
			S_MUL_Y:    ctrl.mul_y     = 1'b1;
			S_SQRT:     ctrl.sqrt_step = 1'b1;
			S_DIV_INIT: ctrl.div_init  = 1'b1;
			S_DIV:      ctrl.div_step  = 1'b1;
			S_SAT:      ctrl.sat       = 1'b1;
			S_DONE:     ctrl.out_load  = out_free;
			default:    ctrl = '0;
		endcase
	end

	// Advance state, load and count down the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_MUL_Y) begin
				cnt_q <= CNT_W'(DIST_W - 1);
			end else if (state_q == S_DIV_INIT) begin
				cnt_q <= CNT_W'(NUM_W - 1);
			end else if ((state_q == S_SQRT || state_q == S_DIV) && !last) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

`default_nettype wire
